// ===== src/pdrf_pkg.sv =====
// Shared constants and codes for the pose detection row filter.
`default_nettype none

package pdrf_pkg;

   // keypoints per detection row
   localparam int KEYPOINTS = 4;
   localparam int PC_W      = $clog2(KEYPOINTS + 1);
   localparam int IDX_W     = (KEYPOINTS > 1) ? $clog2(KEYPOINTS) : 1;

   localparam logic [PC_W-1:0]  COUNT_FULL = PC_W'(KEYPOINTS);
   localparam logic [PC_W-1:0]  COUNT_LAST = PC_W'(KEYPOINTS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(KEYPOINTS - 1);

   // datapath widths
   localparam int COORD_W = 16;  // Q.4 input coordinate
   localparam int PAD_W   = 15;  // Q.4 padding
   localparam int SCALE_W = 24;  // Q8.16 inverse scale
   localparam int DIFF_W  = 18;  // coordinate minus pad, signed
   localparam int MAG_W   = 16;  // magnitude of the difference
   localparam int PROD_W  = MAG_W + SCALE_W;
   localparam int REST_W  = PROD_W - 16 + 2;  // rounded signed restored point
   localparam int POS_W   = 18;
   localparam int PIX_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int CONF_W  = 16;
   localparam int CLASS_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // input item kinds (tuser)
   localparam logic FUNC_HEADER = 1'b0;
   localparam logic FUNC_POINT  = 1'b1;

   // result kinds (tuser)
   localparam logic KIND_BOX   = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_LEFT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_TOP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT  = 3'd6;

   // one stored keypoint
   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [CONF_W-1:0] conf;
   } point_type;

endpackage

`default_nettype wire

// ===== src/pdrf_restore.sv =====
// Letterbox restore unit: round((v - pad) * inverse_scale / 2^16), two register stages.
`default_nettype none

module pdrf_restore (
   input  logic                          clock,
   input  logic [pdrf_pkg::COORD_W-1:0]  value_in,
   input  logic [pdrf_pkg::PAD_W-1:0]    pad_in,
   input  logic [pdrf_pkg::SCALE_W-1:0]  scale_in,
   output logic [pdrf_pkg::REST_W-1:0]   result_out
);
   import pdrf_pkg::*;

   logic [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]  diff_neg;
   logic               neg_in;
   logic [MAG_W-1:0]   mag_in;
   logic               neg_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic               neg2_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W:0]    rnd_sum;
   logic [REST_W-1:0]  mag_rnd;

   // stage 1: signed difference, split into sign and magnitude
   always_comb begin
      diff     = {{(DIFF_W-COORD_W){value_in[COORD_W-1]}}, value_in}
               - {{(DIFF_W-PAD_W){1'b0}}, pad_in};
      diff_neg = -diff;
      neg_in   = diff[DIFF_W-1];
      mag_in   = neg_in ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
   end

   // stage 2: unsigned multiply by the inverse scale
   assign prod_in = mag_ff * scale_in;

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      neg2_ff <= neg_ff;
      prod_ff <= prod_in;
   end

   // round half away from zero, then reapply the sign
   always_comb begin
      rnd_sum    = {1'b0, prod_ff} + (PROD_W+1)'(32768);
      mag_rnd    = {1'b0, rnd_sum[PROD_W:16]};
      result_out = neg2_ff ? -mag_rnd : mag_rnd;
   end

endmodule

`default_nettype wire

// ===== src/pose_detection_row_filter.sv =====
// Top level of the pose detection row filter: row sequencer, point memory and output register.
//
// Rows arrive as a header beat (tuser 0: two box corners, score, class) followed by
// KEYPOINTS keypoint beats (tuser 1). Each point is restored from letterbox space as
// round((v - pad) * inverse_scale / 2^16) by two restore units (x and y) built as a
// subtract stage and a 16x24 multiply stage. A keypoint beat passes through ST_IDLE
// (accept), ST_FIRST and ST_SECOND (pipeline fill) and ST_PAIR_A (result), a header
// beat also through ST_PAIR_B; this sequence is set by the restore pipeline. Restored
// keypoints are kept in a KEYPOINTS-entry point memory with a registered read port.
// When the last keypoint of a passing row is in, the block sends one box beat and
// then the keypoints, one memory read per keypoint; the drain stalls while rsp_tready
// is low, and no input is taken during the drain. A finished beat waits in the output
// register while the next input is accepted. Rejected rows (low score, class not 0,
// low keypoint confidence, empty box) produce nothing. A header inside a row restarts
// the row; extra keypoints after a complete row are dropped. The point memory needs
// no clearing after reset. Configuration is written through csr_we/csr_index/csr_wdata;
// the user must write it only while the block is idle; the block itself does not enforce it.
`default_nettype none

module pose_detection_row_filter (
   input  logic                             clock,
   input  logic                             reset,
   // input item
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_x[15:0], first_y[31:16], second_x[47:32], second_y[63:48],
   // confidence_in[79:64], class_index[87:80]
   input  logic [87:0]                      req_tdata,
   input  logic                             req_tuser,  // func
   // result item
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pos_a[17:0], pos_b[35:18], box_right[47:36], box_bottom[59:48],
   // confidence_out[75:60], zero fill[79:76]
   output logic [79:0]                      rsp_tdata,
   output logic                             rsp_tuser,  // kind
   output logic                             rsp_tlast,  // last
   // configuration write port
   input  logic                             csr_we,
   input  logic [pdrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pdrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pdrf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,      // first pair enters the restore units
      ST_SECOND,     // second pair enters, first pair is multiplied
      ST_PAIR_A,     // first pair restored
      ST_PAIR_B,     // second pair restored (header only)
      ST_EMIT_BOX,
      ST_EMIT_PT
   } state_type;

   // sequencer state
   state_type         state_ff, state_in;
   logic [PC_W-1:0]   counter_ff, counter_in;
   logic              rejected_ff, rejected_in;
   logic [IDX_W-1:0]  emit_idx_ff, emit_idx_in;

   // captured input beat
   logic              item_func_ff, item_func_in;
   logic [COORD_W-1:0] item_ax_ff, item_ax_in;
   logic [COORD_W-1:0] item_ay_ff, item_ay_in;
   logic [COORD_W-1:0] item_bx_ff, item_bx_in;
   logic [COORD_W-1:0] item_by_ff, item_by_in;
   logic [CONF_W-1:0] item_conf_ff, item_conf_in;
   logic [CLASS_W-1:0] item_class_ff, item_class_in;

   // box state
   logic [PIX_W-1:0]  ax_ff, ax_in;
   logic [PIX_W-1:0]  ay_ff, ay_in;
   logic [PIX_W-1:0]  left_ff, left_in;
   logic [PIX_W-1:0]  top_ff, top_in;
   logic [PIX_W-1:0]  right_ff, right_in;
   logic [PIX_W-1:0]  bottom_ff, bottom_in;
   logic [CONF_W-1:0] score_ff, score_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0]  rsp_pos_a_ff, rsp_pos_a_in;
   logic [POS_W-1:0]  rsp_pos_b_ff, rsp_pos_b_in;
   logic [PIX_W-1:0]  rsp_right_ff, rsp_right_in;
   logic [PIX_W-1:0]  rsp_bottom_ff, rsp_bottom_in;
   logic [CONF_W-1:0] rsp_conf_ff, rsp_conf_in;
   logic              rsp_last_ff, rsp_last_in;

   // configuration registers
   logic [CONF_W-1:0]  score_limit_ff, score_limit_in;
   logic [CONF_W-1:0]  point_limit_ff, point_limit_in;
   logic [PAD_W-1:0]   pad_left_ff, pad_left_in;
   logic [PAD_W-1:0]   pad_top_ff, pad_top_in;
   logic [SCALE_W-1:0] inv_scale_ff, inv_scale_in;
   logic [SIZE_W-1:0]  img_width_ff, img_width_in;
   logic [SIZE_W-1:0]  img_height_ff, img_height_in;

   // point memory
   point_type         point_mem [KEYPOINTS];
   point_type         mem_rd_ff;
   point_type         mem_wdata;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;

   // restore datapath
   logic [COORD_W-1:0] rx_value;
   logic [COORD_W-1:0] ry_value;
   logic [REST_W-1:0]  rest_x;
   logic [REST_W-1:0]  rest_y;
   logic [PIX_W-1:0]   px_x;
   logic [PIX_W-1:0]   px_y;
   logic               slot_free;
   logic               point_rej;

   // clamp a restored Q.4 coordinate to [0, (size-1)*16], size capped at 4096 (0 for size 0), and round to a pixel
   function automatic logic [PIX_W-1:0] to_pixel(input logic [REST_W-1:0] q,
                                                 input logic [SIZE_W-1:0] size);
      logic [PIX_W-1:0]  last_px;
      logic [15:0]       hi;
      logic [15:0]       clamped;
      logic [15:0]       sum;
      if (size == '0) begin
         last_px = '0;
      end else if (size > SIZE_W'(4096)) begin
         last_px = '1;
      end else begin
         last_px = size[PIX_W-1:0] - PIX_W'(1);
      end
      hi = {last_px, 4'b0000};
      if (q[REST_W-1]) begin
         clamped = '0;
      end else if (q[REST_W-2:0] > {{(REST_W-17){1'b0}}, hi}) begin
         clamped = hi;
      end else begin
         clamped = q[15:0];
      end
      sum = clamped + 16'd8;
      return sum[15:4];
   endfunction

   // saturate to signed 18 bits
   function automatic logic [POS_W-1:0] sat18(input logic [REST_W-1:0] q);
      logic [POS_W-1:0] r;
      if (!q[REST_W-1] && (|q[REST_W-2:POS_W-1])) begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end else if (q[REST_W-1] && !(&q[REST_W-2:POS_W-1])) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = q[POS_W-1:0];
      end
      return r;
   endfunction

   // header reuses the units for its second corner in the cycle after its first
   assign rx_value = (state_ff == ST_SECOND) ? item_bx_ff : item_ax_ff;
   assign ry_value = (state_ff == ST_SECOND) ? item_by_ff : item_ay_ff;

   pdrf_restore u_restore_x (
      .clock      (clock),
      .value_in   (rx_value),
      .pad_in     (pad_left_ff),
      .scale_in   (inv_scale_ff),
      .result_out (rest_x)
   );

   pdrf_restore u_restore_y (
      .clock      (clock),
      .value_in   (ry_value),
      .pad_in     (pad_top_ff),
      .scale_in   (inv_scale_ff),
      .result_out (rest_y)
   );

   assign px_x = to_pixel(rest_x, img_width_ff);
   assign px_y = to_pixel(rest_y, img_height_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign point_rej  = item_conf_ff < point_limit_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_conf_ff, rsp_bottom_ff, rsp_right_ff,
                        rsp_pos_b_ff, rsp_pos_a_ff};

   always_comb begin
      state_in       = state_ff;
      counter_in     = counter_ff;
      rejected_in    = rejected_ff;
      emit_idx_in    = emit_idx_ff;
      item_func_in   = item_func_ff;
      item_ax_in     = item_ax_ff;
      item_ay_in     = item_ay_ff;
      item_bx_in     = item_bx_ff;
      item_by_in     = item_by_ff;
      item_conf_in   = item_conf_ff;
      item_class_in  = item_class_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      left_in        = left_ff;
      top_in         = top_ff;
      right_in       = right_ff;
      bottom_in      = bottom_ff;
      score_in       = score_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_pos_a_in   = rsp_pos_a_ff;
      rsp_pos_b_in   = rsp_pos_b_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_bottom_in  = rsp_bottom_ff;
      rsp_conf_in    = rsp_conf_ff;
      rsp_last_in    = rsp_last_ff;
      score_limit_in = score_limit_ff;
      point_limit_in = point_limit_ff;
      pad_left_in    = pad_left_ff;
      pad_top_in     = pad_top_ff;
      inv_scale_in   = inv_scale_ff;
      img_width_in   = img_width_ff;
      img_height_in  = img_height_ff;
      mem_we         = 1'b0;
      mem_waddr      = counter_ff[IDX_W-1:0];
      mem_wdata      = '{x: sat18(rest_x), y: sat18(rest_y), conf: item_conf_ff};
      mem_re         = 1'b0;
      mem_raddr      = '0;

      // configuration
      if (csr_we) begin
         case (csr_index)
            CSR_SCORE_LIMIT: score_limit_in = csr_wdata[CONF_W-1:0];
            CSR_POINT_LIMIT: point_limit_in = csr_wdata[CONF_W-1:0];
            CSR_PAD_LEFT:    pad_left_in    = csr_wdata[PAD_W-1:0];
            CSR_PAD_TOP:     pad_top_in     = csr_wdata[PAD_W-1:0];
            CSR_INV_SCALE:   inv_scale_in   = csr_wdata[SCALE_W-1:0];
            CSR_IMG_WIDTH:   img_width_in   = csr_wdata[SIZE_W-1:0];
            CSR_IMG_HEIGHT:  img_height_in  = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end

      // beat taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_func_in  = req_tuser;
               item_ax_in    = req_tdata[15:0];
               item_ay_in    = req_tdata[31:16];
               item_bx_in    = req_tdata[47:32];
               item_by_in    = req_tdata[63:48];
               item_conf_in  = req_tdata[79:64];
               item_class_in = req_tdata[87:80];
               state_in      = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = ST_SECOND;
         end
         ST_SECOND: begin
            state_in = ST_PAIR_A;
         end
         ST_PAIR_A: begin
            state_in = ST_IDLE;
            if (item_func_ff == FUNC_HEADER) begin
               ax_in    = px_x;
               ay_in    = px_y;
               state_in = ST_PAIR_B;
            end else if (counter_ff < COUNT_FULL) begin
               // keypoint of an open row: store it
               mem_we      = 1'b1;
               rejected_in = rejected_ff || point_rej;
               counter_in  = counter_ff + PC_W'(1);
               if (counter_ff == COUNT_LAST && !(rejected_ff || point_rej)) begin
                  state_in = ST_EMIT_BOX;
               end
            end
         end
         ST_PAIR_B: begin
            left_in     = (ax_ff < px_x) ? ax_ff : px_x;
            right_in    = (ax_ff < px_x) ? px_x : ax_ff;
            top_in      = (ay_ff < px_y) ? ay_ff : px_y;
            bottom_in   = (ay_ff < px_y) ? px_y : ay_ff;
            score_in    = item_conf_ff;
            counter_in  = '0;
            rejected_in = (item_conf_ff < score_limit_ff) || (item_class_ff != '0)
                       || (right_in <= left_in) || (bottom_in <= top_in);
            state_in    = ST_IDLE;
         end
         ST_EMIT_BOX: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_BOX;
               rsp_pos_a_in  = {{(POS_W-PIX_W){1'b0}}, left_ff};
               rsp_pos_b_in  = {{(POS_W-PIX_W){1'b0}}, top_ff};
               rsp_right_in  = right_ff;
               rsp_bottom_in = bottom_ff;
               rsp_conf_in   = score_ff;
               rsp_last_in   = 1'b0;
               mem_re        = 1'b1;
               mem_raddr     = '0;
               emit_idx_in   = '0;
               state_in      = ST_EMIT_PT;
            end
         end
         ST_EMIT_PT: begin
            // mem_rd_ff holds entry emit_idx_ff; it only advances with a beat
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_POINT;
               rsp_pos_a_in  = mem_rd_ff.x;
               rsp_pos_b_in  = mem_rd_ff.y;
               rsp_right_in  = '0;
               rsp_bottom_in = '0;
               rsp_conf_in   = mem_rd_ff.conf;
               rsp_last_in   = (emit_idx_ff == LAST_IDX);
               if (emit_idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + IDX_W'(1);
                  mem_re      = 1'b1;
                  mem_raddr   = emit_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         counter_ff     <= '0;
         rejected_ff    <= 1'b0;
         emit_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         score_limit_ff <= CONF_W'(16384);
         point_limit_ff <= CONF_W'(16384);
         pad_left_ff    <= '0;
         pad_top_ff     <= '0;
         inv_scale_ff   <= SCALE_W'(65536);
         img_width_ff   <= SIZE_W'(640);
         img_height_ff  <= SIZE_W'(640);
      end else begin
         state_ff       <= state_in;
         counter_ff     <= counter_in;
         rejected_ff    <= rejected_in;
         emit_idx_ff    <= emit_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         score_limit_ff <= score_limit_in;
         point_limit_ff <= point_limit_in;
         pad_left_ff    <= pad_left_in;
         pad_top_ff     <= pad_top_in;
         inv_scale_ff   <= inv_scale_in;
         img_width_ff   <= img_width_in;
         img_height_ff  <= img_height_in;
      end
      item_func_ff  <= item_func_in;
      item_ax_ff    <= item_ax_in;
      item_ay_ff    <= item_ay_in;
      item_bx_ff    <= item_bx_in;
      item_by_ff    <= item_by_in;
      item_conf_ff  <= item_conf_in;
      item_class_ff <= item_class_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      left_ff       <= left_in;
      top_ff        <= top_in;
      right_ff      <= right_in;
      bottom_ff     <= bottom_in;
      score_ff      <= score_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_pos_a_ff  <= rsp_pos_a_in;
      rsp_pos_b_ff  <= rsp_pos_b_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_conf_ff   <= rsp_conf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // point memory: writes while filling, reads only while draining
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= point_mem[mem_raddr];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      counter_ff <= COUNT_FULL)
      else $error("keypoint count past row length");

   a_write_open_row: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (counter_ff < COUNT_FULL) && (state_ff == ST_PAIR_A))
      else $error("point memory written outside an open row");

   a_drain_passing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_BOX) |-> !rejected_ff && (counter_ff == COUNT_FULL))
      else $error("drain started for an incomplete or rejected row");

   a_read_in_drain: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (state_ff == ST_EMIT_BOX) || (state_ff == ST_EMIT_PT))
      else $error("point memory read outside the drain");

   a_last_is_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff == KIND_POINT))
      else $error("row end marked on a box beat");
`endif

endmodule

`default_nettype wire
